### rtl/owr_pkg.sv
// ----------------------------------------------------------------------------
// owr_pkg
// Shared types, constants and pointer helpers for the overwrite-oldest ring.
// ----------------------------------------------------------------------------
package owr_pkg;

  localparam int RING_DEPTH = 256;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int OCC_W      = 8;
  localparam int OCC_EXT_W  = (PTR_W > OCC_W) ? PTR_W : OCC_W;

  localparam logic [7:0] PURGE_RESET = 8'h43;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_PURGE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_PURGE
  } state_t;

  typedef struct packed {
    logic [7:0]       pop_byte;
    logic             pop_valid;
    logic             dropped;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  function automatic ptr_t ring_next(ptr_t p);
    ring_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic ptr_t ring_used(ptr_t wr, ptr_t rd);
    logic [PTR_W:0] wrap;
    wrap = {1'b0, wr} + (PTR_W+1)'(RING_DEPTH) - {1'b0, rd};
    ring_used = (wr >= rd) ? (wr - rd) : wrap[PTR_W-1:0];
  endfunction

  function automatic logic [OCC_W-1:0] occ_sat(ptr_t u);
    logic [OCC_EXT_W-1:0] e;
    e = OCC_EXT_W'(u);
    occ_sat = (e > OCC_EXT_W'(255)) ? 8'hFF : e[OCC_W-1:0];
  endfunction

endpackage

### rtl/owr_ram.sv
// ----------------------------------------------------------------------------
// owr_ram
// Byte store of the ring: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module owr_ram
  import owr_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  ptr_t       wr_addr,
  input  logic [7:0] wr_data,
  input  logic       rd_en,
  input  ptr_t       rd_addr,
  output logic [7:0] rd_data
);

  logic [7:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/owr_core.sv
// ----------------------------------------------------------------------------
// owr_core
// Pointer control, command sequencer and purge walk over the ring store.
// ----------------------------------------------------------------------------
module owr_core
  import owr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req,
  input  cmd_e       req_cmd,
  input  logic [7:0] req_byte,
  input  logic [7:0] purge_value,
  output logic       idle,
  output logic       res_valid,
  output result_t    res
);

  state_t     state, state_next;
  ptr_t       wr_ptr, wr_ptr_next;
  ptr_t       rd_ptr, rd_ptr_next;
  ptr_t       src, src_next;
  ptr_t       dst, dst_next;
  ptr_t       left, left_next;
  logic       pend, pend_next;

  logic       ram_wr_en;
  ptr_t       ram_wr_addr;
  logic       ram_rd_en;
  ptr_t       ram_rd_addr;
  logic [7:0] ram_rd_data;

  ptr_t       wr_inc;
  logic       full;
  ptr_t       used_now;

  assign wr_inc   = ring_next(wr_ptr);
  assign full     = (wr_inc == rd_ptr);
  assign used_now = ring_used(wr_ptr, rd_ptr);
  assign idle     = (state == ST_IDLE);

  owr_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_en && state == ST_PURGE ? ram_rd_data : req_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      wr_ptr <= '0;
      rd_ptr <= '0;
      src    <= '0;
      dst    <= '0;
      left   <= '0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      src    <= src_next;
      dst    <= dst_next;
      left   <= left_next;
      pend   <= pend_next;
    end
  end

  always_comb begin
    state_next  = state;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    src_next    = src;
    dst_next    = dst;
    left_next   = left;
    pend_next   = pend;
    ram_wr_en   = 1'b0;
    ram_wr_addr = wr_ptr;
    ram_rd_en   = 1'b0;
    ram_rd_addr = rd_ptr;
    res_valid   = 1'b0;
    res         = '0;

    case (state)
      ST_IDLE: begin
        if (req) begin
          case (req_cmd)
            CMD_PUSH: begin
              ram_wr_en   = 1'b1;
              wr_ptr_next = wr_inc;
              if (full) begin
                rd_ptr_next = ring_next(rd_ptr);
                res.dropped = 1'b1;
              end
              res_valid     = 1'b1;
              res.occupancy = occ_sat(ring_used(wr_ptr_next, rd_ptr_next));
            end
            CMD_POP: begin
              if (wr_ptr == rd_ptr) begin
                res_valid = 1'b1;
              end else begin
                ram_rd_en   = 1'b1;
                rd_ptr_next = ring_next(rd_ptr);
                state_next  = ST_POP;
              end
            end
            CMD_FLUSH: begin
              wr_ptr_next = '0;
              rd_ptr_next = '0;
              res_valid   = 1'b1;
            end
            CMD_PURGE: begin
              if (used_now == '0) begin
                res_valid = 1'b1;
              end else begin
                src_next   = rd_ptr;
                dst_next   = rd_ptr;
                left_next  = used_now;
                pend_next  = 1'b0;
                state_next = ST_PURGE;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        res_valid     = 1'b1;
        res.pop_byte  = ram_rd_data;
        res.pop_valid = 1'b1;
        res.occupancy = occ_sat(used_now);
        state_next    = ST_IDLE;
      end
      ST_PURGE: begin
        if (pend && ram_rd_data != purge_value) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = dst;
          dst_next    = ring_next(dst);
        end
        if (left != '0) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = src;
          src_next    = ring_next(src);
          left_next   = left - PTR_W'(1);
          pend_next   = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (left == '0 && !pend) begin
          wr_ptr_next   = dst;
          res_valid     = 1'b1;
          res.occupancy = occ_sat(ring_used(dst, rd_ptr));
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_no_req_in_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_PURGE |-> !req)
    else $error("request taken during purge walk");

  a_pop_returns: assert property (@(posedge clk) disable iff (rst)
    idle && req && req_cmd == CMD_POP && wr_ptr != rd_ptr |=> res_valid && res.pop_valid)
    else $error("pop on non-empty ring gave no byte");

  a_walk_reads: assert property (@(posedge clk) disable iff (rst)
    state == ST_PURGE && left != '0 |=> pend)
    else $error("purge walk lost a pending read");

  a_dst_behind: assert property (@(posedge clk) disable iff (rst)
    state == ST_PURGE |-> ring_used(dst, rd_ptr) <= ring_used(src, rd_ptr)
                          || src == rd_ptr)
    else $error("purge write pointer passed read pointer");
`endif

endmodule

### rtl/overwrite_oldest_byte_ring_top.sv
// ----------------------------------------------------------------------------
// overwrite_oldest_byte_ring_top
// Byte receive ring that drops its oldest byte on overflow, with pop, flush
// and purge of a configured byte value.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tuser: cmd; tdata: push_byte
//   m_*      out  m_tvalid/m_tready    tuser: pop_valid, dropped;
//                                      tdata: pop_byte, occupancy
//   cfg_*    in   cfg_valid/cfg_ready  cfg_data: purge_value
//
// Push, flush, and pop or purge on an empty ring, answer from the idle state.
// Pop answers through a registered store read. Purge walks the stored bytes,
// reading one store entry per cycle, kept unless it equals the purge value.
// A request is taken while the sequencer is idle and the output register is
// empty or being drained. Synchronous reset empties the ring; no clearing pass.
// ----------------------------------------------------------------------------
module overwrite_oldest_byte_ring_top
  import owr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] push_byte
  input  logic [1:0]  s_tuser,   // [1:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] pop_byte, [15:8] occupancy
  output logic [1:0]  m_tuser,   // [0] pop_valid, [1] dropped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] purge_value;
  logic       core_idle;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  logic       req;

  assign cfg_ready = 1'b1;
  assign s_tready  = core_idle && (!m_tvalid || m_tready);
  assign req       = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      purge_value <= PURGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      purge_value <= cfg_data;
    end
  end

  owr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .req_cmd     (cmd_e'(s_tuser)),
    .req_byte    (s_tdata),
    .purge_value (purge_value),
    .idle        (core_idle),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.occupancy, out_res.pop_byte};
  assign m_tuser = {out_res.dropped, out_res.pop_valid};

endmodule
